[src/mco_pkg.sv]
// shared widths and defaults for the matrix chain order block
`timescale 1ns / 1ps

package mco_pkg;

    localparam int DIM_W              = 16;
    localparam int IDX_W              = 4;
    localparam int COST_W             = 51;
    localparam int DEF_MAX_MATRICES   = 8;
    localparam int DEF_DIM_BITS       = 16;

    typedef logic [DIM_W-1:0]  t_dim;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [COST_W-1:0] t_cost;

endpackage

[src/mco_if.sv]
// valid/ready channels for dimension input and sub-chain results
`timescale 1ns / 1ps

interface mco_dim_if;
    logic               valid;
    logic               ready;
    mco_pkg::t_dim      dim;
    logic               last_dim;

    modport source (output valid, output dim, output last_dim, input ready);
    modport sink   (input valid, input dim, input last_dim, output ready);
endinterface

interface mco_res_if;
    logic               valid;
    logic               ready;
    mco_pkg::t_idx      row;
    mco_pkg::t_idx      col;
    mco_pkg::t_idx      split;
    mco_pkg::t_cost     cost;
    logic               error;
    logic               last;

    modport source (output valid, output row, output col, output split,
                    output cost, output error, output last, input ready);
    modport sink   (input valid, input row, input col, input split,
                    input cost, input error, input last, output ready);
endinterface

[src/matrix_chain_order_unit.sv]
// matrix chain order unit: dimension capture, cost table fill and result output
`timescale 1ns / 1ps

// Dimensions enter on i_in one per transfer; last_dim marks the final one.
// Matrix m is dim[m-1] by dim[m]. Up to MAX_MATRICES+1 dimensions are kept,
// extra ones set an overflow flag. After the final dimension the unit emits
// one result on o_out per sub-chain (row, col) of length two or more, in
// order of length and then start, with the best split and its cost; the
// whole chain comes last with last set. One matrix gives a single result
// with cost 0; too few or too many dimensions give one result with error.
// Dimensions are accepted only while the unit is idle. A run starts with a
// decode step; each sub-chain then takes cell set-up steps, five steps per
// split point (read, two multiplies, add, compare) and a write-back step.
// i_in.ready is low during the run. A stalled receiver holds the current
// result in the output register and the sequencer waits.
// Synchronous reset clears the sequencer, the dimension counter, the
// overflow flag and output valid; the dimension and cost memories are not
// cleared and need no clearing pass.
module matrix_chain_order_unit #(
    parameter int MAX_MATRICES = mco_pkg::DEF_MAX_MATRICES,
    parameter int DIM_BITS     = mco_pkg::DEF_DIM_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mco_dim_if.sink    i_in,
    mco_res_if.source  o_out
);
    import mco_pkg::*;

    localparam int NDIM  = MAX_MATRICES + 1;
    localparam int IW    = $clog2(MAX_MATRICES + 1);
    localparam int CW    = $clog2(MAX_MATRICES + 2);
    localparam int DAW   = $clog2(NDIM);
    localparam int DEPTH = MAX_MATRICES * MAX_MATRICES;
    localparam int AW    = $clog2(DEPTH);
    localparam int P1W   = 2 * DIM_BITS;
    localparam int P2W   = 3 * DIM_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_CELL_A, S_CELL_B, S_K_RD, S_K_MUL1,
        S_K_MUL2, S_K_ADD, S_K_CMP, S_WB
    } t_state;

    t_state                 r_state;
    logic [CW-1:0]          r_cnt;
    logic                   r_ovf;
    logic                   r_err;
    logic [IW-1:0]          r_n;
    logic [IW-1:0]          r_len;
    logic [IW-1:0]          r_i;
    logic [IW-1:0]          r_k;
    logic [IW-1:0]          r_best_k;
    logic                   r_have;
    logic                   r_ldiag;
    logic                   r_rdiag;
    logic [DIM_BITS-1:0]    r_di;
    logic [DIM_BITS-1:0]    r_dj;
    logic [P1W-1:0]         r_p1;
    logic [P2W-1:0]         r_prod;
    t_cost                  r_sum;
    t_cost                  r_q;
    t_cost                  r_best;

    logic                   r_out_valid;
    t_idx                   r_out_row;
    t_idx                   r_out_col;
    t_idx                   r_out_split;
    t_cost                  r_out_cost;
    logic                   r_out_error;
    logic                   r_out_last;

    logic [DIM_BITS-1:0]    dims_mem [NDIM];
    t_cost                  cost_mem [DEPTH];
    logic [DIM_BITS-1:0]    r_dim_rd;
    t_cost                  r_c1_rd;
    t_cost                  r_c2_rd;

    logic                   in_xfer;
    logic                   out_free;
    logic                   has_room;
    logic [CW-1:0]          n_cnt;
    logic                   n_ovf;
    logic [IW-1:0]          j_idx;
    logic [DAW-1:0]         dim_raddr;
    logic [AW-1:0]          addr_a;
    logic [AW-1:0]          addr_b;
    logic [AW-1:0]          addr_w;
    logic                   cost_we;
    t_cost                  c1_val;
    t_cost                  c2_val;

    function automatic logic [AW-1:0] cell_addr(logic [IW-1:0] a, logic [IW-1:0] b);
        int v;
        v = (int'(a) - 1) * MAX_MATRICES + (int'(b) - 1);
        return AW'(v);
    endfunction

    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign has_room = int'(r_cnt) < NDIM;
    assign n_cnt    = has_room ? r_cnt + CW'(1) : r_cnt;
    assign n_ovf    = r_ovf || !has_room;
    assign j_idx    = r_i + r_len - IW'(1);

    assign i_in.ready = (r_state == S_IDLE);

    always_comb begin
        dim_raddr = '0;
        unique case (r_state)
            S_CELL_A: dim_raddr = DAW'(r_i - IW'(1));
            S_CELL_B: dim_raddr = DAW'(j_idx);
            S_K_RD:   dim_raddr = DAW'(r_k);
            default:  dim_raddr = '0;
        endcase
    end

    assign addr_a  = cell_addr(r_i, r_k);
    assign addr_b  = cell_addr(r_k + IW'(1), j_idx);
    assign addr_w  = cell_addr(r_i, j_idx);
    assign cost_we = (r_state == S_WB) && out_free;

    // diagonal entries cost nothing, so they are never stored
    assign c1_val = r_ldiag ? '0 : r_c1_rd;
    assign c2_val = r_rdiag ? '0 : r_c2_rd;

    always_ff @(posedge i_clk) begin
        if (in_xfer && has_room) begin
            dims_mem[DAW'(r_cnt)] <= i_in.dim[DIM_BITS-1:0];
        end
        r_dim_rd <= dims_mem[dim_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (cost_we) begin
            cost_mem[addr_w] <= r_best;
        end
        r_c1_rd <= cost_mem[addr_a];
        r_c2_rd <= cost_mem[addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        if (i_in.last_dim) begin
                            r_err   <= n_ovf || (int'(n_cnt) < 2);
                            r_n     <= IW'(n_cnt - CW'(1));
                            r_cnt   <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= S_DECIDE;
                        end else begin
                            r_cnt <= n_cnt;
                            r_ovf <= n_ovf;
                        end
                    end
                end
                S_DECIDE: begin
                    if (r_err || r_n == IW'(1)) begin
                        if (out_free) begin
                            r_out_valid <= 1'b1;
                            r_out_row   <= r_err ? '0 : t_idx'(1);
                            r_out_col   <= r_err ? '0 : t_idx'(1);
                            r_out_split <= r_err ? '0 : t_idx'(1);
                            r_out_cost  <= '0;
                            r_out_error <= r_err;
                            r_out_last  <= 1'b1;
                            r_state     <= S_IDLE;
                        end
                    end else begin
                        r_len   <= IW'(2);
                        r_i     <= IW'(1);
                        r_state <= S_CELL_A;
                    end
                end
                S_CELL_A: begin
                    r_state <= S_CELL_B;
                end
                S_CELL_B: begin
                    r_di    <= r_dim_rd;
                    r_k     <= r_i;
                    r_have  <= 1'b0;
                    r_state <= S_K_RD;
                end
                S_K_RD: begin
                    // on the first split point the read register still holds dim[j]
                    if (r_k == r_i) begin
                        r_dj <= r_dim_rd;
                    end
                    r_ldiag <= (r_k == r_i);
                    r_rdiag <= (r_k + IW'(1) == j_idx);
                    r_state <= S_K_MUL1;
                end
                S_K_MUL1: begin
                    r_p1    <= r_di * r_dim_rd;
                    r_state <= S_K_MUL2;
                end
                S_K_MUL2: begin
                    r_prod  <= r_p1 * r_dj;
                    r_sum   <= c1_val + c2_val;
                    r_state <= S_K_ADD;
                end
                S_K_ADD: begin
                    r_q     <= r_sum + COST_W'(r_prod);
                    r_state <= S_K_CMP;
                end
                S_K_CMP: begin
                    // strict compare keeps the smallest split on ties
                    if (!r_have || r_q < r_best) begin
                        r_best   <= r_q;
                        r_best_k <= r_k;
                        r_have   <= 1'b1;
                    end
                    if (r_k + IW'(1) == j_idx) begin
                        r_state <= S_WB;
                    end else begin
                        r_k     <= r_k + IW'(1);
                        r_state <= S_K_RD;
                    end
                end
                S_WB: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_row   <= t_idx'(r_i);
                        r_out_col   <= t_idx'(j_idx);
                        r_out_split <= t_idx'(r_best_k);
                        r_out_cost  <= r_best;
                        r_out_error <= 1'b0;
                        r_out_last  <= (r_len == r_n);
                        if (j_idx == r_n) begin
                            if (r_len == r_n) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_len   <= r_len + IW'(1);
                                r_i     <= IW'(1);
                                r_state <= S_CELL_A;
                            end
                        end else begin
                            r_i     <= r_i + IW'(1);
                            r_state <= S_CELL_A;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.row   = r_out_row;
    assign o_out.col   = r_out_col;
    assign o_out.split = r_out_split;
    assign o_out.cost  = r_out_cost;
    assign o_out.error = r_out_error;
    assign o_out.last  = r_out_last;

endmodule

[test/tb_matrix_chain_order_unit.sv]
// testbench for the matrix chain order unit: dimension stimulus, cost/split prediction, checks
`timescale 1ns / 1ps

module tb_matrix_chain_order_unit;
    import mco_pkg::*;

    localparam int MAX_MAT    = DEF_MAX_MATRICES;
    localparam int RAND_ITEMS = 290;

    typedef enum int {
        RX_ALWAYS  = 0,
        RX_RANDOM  = 1,
        RX_PATTERN = 2,
        RX_SPARSE  = 3
    } t_rx_mode;

    typedef struct {
        t_idx  row;
        t_idx  col;
        t_idx  split;
        t_cost cost;
        logic  error;
        logic  last;
    } t_chain_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mco_dim_if in_ch ();
    mco_res_if out_ch ();

    matrix_chain_order_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    t_dim          chain_dims [0:MAX_MAT];
    int unsigned   dims_taken;
    logic          dims_overflow;
    logic [63:0]   sub_cost [1:MAX_MAT][1:MAX_MAT];
    t_chain_result pending_results [$];
    int            mismatch_count;

    // sender and receiver control
    logic          gaps_on;
    int            burst_left;
    t_rx_mode      rx_mode;
    int            hold_req;
    int            hold_seen;
    int            hold_len;
    int            hold_left;
    logic [15:0]   rx_cycle;

    task automatic push_result(input int r, input int c, input int s, input logic [63:0] q,
                               input logic err, input logic fin);
        t_chain_result e;
        e.row   = t_idx'(r);
        e.col   = t_idx'(c);
        e.split = t_idx'(s);
        e.cost  = t_cost'(q);
        e.error = err;
        e.last  = fin;
        pending_results = {pending_results, e};
    endtask

    // minimum-multiplication fill, results in order of length then start
    task automatic predict_chain_costs(input t_dim d, input logic fin);
        int          n;
        int          j;
        int          best_k;
        logic [63:0] q;
        logic [63:0] best;
        if (dims_taken < MAX_MAT + 1) begin
            chain_dims[dims_taken] = d;
            dims_taken++;
        end else begin
            dims_overflow = 1'b1;
        end
        if (!fin) return;
        if (dims_overflow || dims_taken < 2) begin
            push_result(0, 0, 0, 64'd0, 1'b1, 1'b1);
            dims_taken    = 0;
            dims_overflow = 1'b0;
            return;
        end
        n             = dims_taken - 1;
        dims_taken    = 0;
        dims_overflow = 1'b0;
        if (n == 1) begin
            push_result(1, 1, 1, 64'd0, 1'b0, 1'b1);
            return;
        end
        for (int i = 1; i <= n; i++) sub_cost[i][i] = 64'd0;
        for (int len = 2; len <= n; len++) begin
            for (int i = 1; i + len - 1 <= n; i++) begin
                j      = i + len - 1;
                best   = '1;
                best_k = i;
                for (int k = i; k < j; k++) begin
                    q = sub_cost[i][k] + sub_cost[k+1][j]
                      + 64'(chain_dims[i-1]) * 64'(chain_dims[k]) * 64'(chain_dims[j]);
                    // strict compare keeps the smallest split on ties
                    if (k == i || q < best) begin
                        best   = q;
                        best_k = k;
                    end
                end
                sub_cost[i][j] = best;
                push_result(i, j, best_k, best, 1'b0, len == n);
            end
        end
    endtask

    // one dimension transfer; valid stays high into the next item unless a gap follows
    task automatic send_dim(input t_dim d, input logic fin);
        int gap;
        in_ch.valid    <= 1'b1;
        in_ch.dim      <= d;
        in_ch.last_dim <= fin;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_chain_costs(d, fin);
        if (gaps_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 8);
                gap        = $urandom_range(0, 6);
                if (gap > 0) begin
                    in_ch.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end else begin
                burst_left--;
            end
        end
    endtask

    function automatic t_dim pick_dim(input int flavor);
        case (flavor)
            0: pick_dim = t_dim'($urandom_range(0, 65535));
            1: pick_dim = t_dim'($urandom_range(0, 15));
            2: pick_dim = ($urandom_range(0, 1) != 0) ? t_dim'($urandom_range(65500, 65535))
                                                        : t_dim'($urandom_range(0, 3));
            default: pick_dim = t_dim'($urandom_range(1, 300));
        endcase
    endfunction

    task automatic send_chain(input int n_dims, input int flavor);
        for (int m = 0; m < n_dims; m++) send_dim(pick_dim(flavor), m == n_dims - 1);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_too_few_dims();
        send_dim(16'h1234, 1'b1);
    endtask

    task automatic test_one_matrix();
        send_dim(16'h0000, 1'b0);
        send_dim(16'hFFFF, 1'b1);
    endtask

    // all dims at the top: largest costs and a tie at every split
    task automatic test_full_chain_max();
        for (int m = 0; m <= MAX_MAT; m++) send_dim(16'hFFFF, m == MAX_MAT);
    endtask

    task automatic test_overflow();
        send_chain(MAX_MAT + 2, 0);
    endtask

    task automatic test_zero_dims();
        send_dim(16'h0000, 1'b0);
        send_dim(16'h0000, 1'b0);
        send_dim(16'h0000, 1'b1);
    endtask

    task automatic test_random_chains();
        int sent;
        int pick;
        int n_dims;
        sent = 0;
        while (sent < RAND_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                n_dims = 1;
            else if (pick < 16)
                n_dims = $urandom_range(MAX_MAT + 2, MAX_MAT + 4);
            else
                n_dims = $urandom_range(2, MAX_MAT + 1);
            gaps_on = ($urandom_range(0, 3) != 0);
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            send_chain(n_dims, $urandom_range(0, 3));
            sent += n_dims;
        end
    endtask

    // receiver holds off while the sender keeps offering dimensions
    task automatic test_backpressure();
        gaps_on  = 1'b0;
        rx_mode  = RX_ALWAYS;
        hold_len = 700;
        hold_req++;
        send_chain(MAX_MAT + 1, 0);
        send_chain(MAX_MAT + 1, 3);
        send_chain(4, 1);
    endtask

    task automatic test_drain_pause();
        gaps_on = 1'b1;
        rx_mode = RX_RANDOM;
        send_chain(6, 0);
        in_ch.valid <= 1'b0;
        wait_drained();
        @(posedge i_clk);
        send_chain(MAX_MAT + 1, 2);
    endtask

    // result receiver
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 16'd1;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen    <= hold_req;
            hold_left    <= hold_len;
            out_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS:  out_ch.ready <= 1'b1;
                RX_RANDOM:  out_ch.ready <= ($urandom_range(0, 1) != 0);
                RX_PATTERN: out_ch.ready <= (rx_cycle[2:0] != 3'b101) && !rx_cycle[5];
                default:    out_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_chain_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer: row %0d col %0d cost %0d",
                       out_ch.row, out_ch.col, out_ch.cost);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (out_ch.row !== want.row) begin
                    $error("row: expected %0d, actual %0d", want.row, out_ch.row);
                    mismatch_count++;
                end
                if (out_ch.col !== want.col) begin
                    $error("col: expected %0d, actual %0d", want.col, out_ch.col);
                    mismatch_count++;
                end
                if (out_ch.split !== want.split) begin
                    $error("split: expected %0d, actual %0d", want.split, out_ch.split);
                    mismatch_count++;
                end
                if (out_ch.cost !== want.cost) begin
                    $error("cost: expected %0d, actual %0d", want.cost, out_ch.cost);
                    mismatch_count++;
                end
                if (out_ch.error !== want.error) begin
                    $error("error: expected %0d, actual %0d", want.error, out_ch.error);
                    mismatch_count++;
                end
                if (out_ch.last !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, out_ch.last);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.dim      = '0;
        in_ch.last_dim = 1'b0;
        out_ch.ready   = 1'b0;
        dims_taken     = 0;
        dims_overflow  = 1'b0;
        mismatch_count = 0;
        gaps_on        = 1'b1;
        burst_left     = 0;
        rx_mode        = RX_RANDOM;
        hold_req       = 0;
        hold_seen      = 0;
        hold_len       = 0;
        hold_left      = 0;
        rx_cycle       = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_too_few_dims();
        test_one_matrix();
        test_full_chain_max();
        test_overflow();
        test_zero_dims();
        test_random_chains();
        test_backpressure();
        test_drain_pause();

        in_ch.valid <= 1'b0;
        wait_drained();
        repeat (600) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
